FILE: design/dnh_pkg.sv
// ----------------------------------------------------------------------------
// Directory name hash package
// Shared payload types and hash constants.
// ----------------------------------------------------------------------------
package dnh_pkg;

   typedef struct packed {
      logic [7:0] name_byte;
      logic [7:0] name_size;
      logic [2:0] hash_mode;
      logic       first_of_name;
   } req_type;

   typedef struct packed {
      logic [31:0] major_word;
      logic [31:0] minor_word;
      logic        hash_error;
   } rsp_type;

   localparam logic [31:0] MD4_IV0 = 32'h67452301;
   localparam logic [31:0] MD4_IV1 = 32'hefcdab89;
   localparam logic [31:0] MD4_IV2 = 32'h98badcfe;
   localparam logic [31:0] MD4_IV3 = 32'h10325476;
   localparam logic [31:0] MD4_K2 = 32'h5a827999;
   localparam logic [31:0] MD4_K3 = 32'h6ed9eba1;
   localparam logic [31:0] TEA_DELTA = 32'h9e3779b9;
   localparam logic [31:0] LEG_MULT = 32'd7152373;
   localparam logic [31:0] LEG_RECENT0 = 32'h12a3fe2d;
   localparam logic [31:0] LEG_OLDER0 = 32'h37abe8f9;
   localparam logic [31:0] LEG_WRAP = 32'h7fffffff;

   // Hash modes: the signed-byte variants come first, then the unsigned ones.
   localparam logic [2:0] MODE_LEGACY = 3'd0;
   localparam logic [2:0] MODE_MD4 = 3'd1;
   localparam logic [2:0] MODE_TEA = 3'd2;
   localparam logic [2:0] MODE_LEGACY_U = 3'd3;
   localparam logic [2:0] MODE_MD4_U = 3'd4;
   localparam logic [2:0] MODE_TEA_U = 3'd5;

   localparam logic [1:0] KIND_LEGACY = 2'd0;
   localparam logic [1:0] KIND_MD4 = 2'd1;
   localparam logic [1:0] KIND_TEA = 2'd2;

   localparam logic [1:0] CSR_SEED0 = 2'd0;

   // Control from the sequencer to the round unit.
   typedef struct packed {
      logic       start;
      logic [1:0] kind;
   } rnd_ctl_type;

endpackage

FILE: design/dnh_round.sv
// ----------------------------------------------------------------------------
// Directory name hash round unit
// Runs one half-MD4 or TEA compression, one MD4 step or TEA half-round per cycle.
// ----------------------------------------------------------------------------
module dnh_round (
   input  logic                 clock,
   input  logic                 reset,
   input  dnh_pkg::rnd_ctl_type ctl,
   input  logic [31:0]          blk [8],
   input  logic [31:0]          chain_in [4],
   output logic [31:0]          chain_out [4],
   output logic                 busy,
   output logic                 done
);
   import dnh_pkg::*;

   logic [31:0] r_ff [4];
   logic [31:0] r_in [4];
   logic [31:0] sum_ff, sum_in;
   logic [4:0]  step_ff, step_in;
   logic        tea_ff;
   logic        busy_ff, done_ff;
   logic        half_ff;
   logic        last_step;

   function automatic logic [2:0] md4_idx(input logic [4:0] s);
      logic [2:0] i;
      i = s[2:0];
      case (s[4:3])
         2'd0: md4_idx = i;
         2'd1: md4_idx = {i[1:0], ~i[2]};
         default: begin
            case (i)
               3'd0: md4_idx = 3'd3;
               3'd1: md4_idx = 3'd7;
               3'd2: md4_idx = 3'd2;
               3'd3: md4_idx = 3'd6;
               3'd4: md4_idx = 3'd1;
               3'd5: md4_idx = 3'd5;
               3'd6: md4_idx = 3'd0;
               default: md4_idx = 3'd4;
            endcase
         end
      endcase
   endfunction

   function automatic logic [4:0] md4_shift(input logic [4:0] s);
      case ({s[4:3], s[1:0]})
         4'b0000: md4_shift = 5'd3;
         4'b0001: md4_shift = 5'd7;
         4'b0010: md4_shift = 5'd11;
         4'b0011: md4_shift = 5'd19;
         4'b0100: md4_shift = 5'd3;
         4'b0101: md4_shift = 5'd5;
         4'b0110: md4_shift = 5'd9;
         4'b0111: md4_shift = 5'd13;
         4'b1000: md4_shift = 5'd3;
         4'b1001: md4_shift = 5'd9;
         4'b1010: md4_shift = 5'd11;
         default: md4_shift = 5'd15;
      endcase
   endfunction

   logic [1:0]  t;
   logic [31:0] x, y, z, fv, kv, acc, rot, tv, tea_r, tea_new;
   logic [4:0]  sh;

   always_comb begin
      r_in = r_ff;
      sum_in = sum_ff;
      t = 2'(3'd4 - {1'b0, step_ff[1:0]});
      x = r_ff[t + 2'd1];
      y = r_ff[t + 2'd2];
      z = r_ff[t + 2'd3];
      case (step_ff[4:3])
         2'd0: begin fv = z ^ (x & (y ^ z)); kv = '0; end
         2'd1: begin fv = (x & y) + ((x ^ y) & z); kv = MD4_K2; end
         default: begin fv = x ^ y ^ z; kv = MD4_K3; end
      endcase
      sh = md4_shift(step_ff);
      acc = r_ff[t] + fv + blk[md4_idx(step_ff)] + kv;
      rot = (acc << sh) | (acc >> (6'd32 - {1'b0, sh}));
      // TEA: half_ff low updates l with sum advanced, high updates r.
      tea_r = half_ff ? r_ff[0] : r_ff[1];
      tv = half_ff ? sum_ff : sum_ff + TEA_DELTA;
      tea_new = ((tea_r << 4) + (half_ff ? blk[2] : blk[0])) ^ (tea_r + tv)
              ^ ((tea_r >> 5) + (half_ff ? blk[3] : blk[1]));
      if (tea_ff) begin
         if (half_ff) r_in[1] = r_ff[1] + tea_new;
         else begin
            r_in[0] = r_ff[0] + tea_new;
            sum_in = tv;
         end
      end else begin
         r_in[t] = rot;
      end
   end

   assign step_in = step_ff + 5'd1;
   assign last_step = tea_ff ? (half_ff && step_ff == 5'd15) : (step_ff == 5'd23);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         half_ff <= 1'b0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         tea_ff <= (ctl.kind == KIND_TEA);
         step_ff <= '0;
         half_ff <= 1'b0;
         sum_ff <= '0;
         r_ff <= chain_in;
      end else if (busy_ff) begin
         r_ff <= r_in;
         sum_ff <= sum_in;
         if (tea_ff) half_ff <= ~half_ff;
         if (!tea_ff || half_ff) step_ff <= step_in;
         busy_ff <= !last_step;
         done_ff <= last_step;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) chain_out[i] = chain_in[i] + r_ff[i];
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule

FILE: design/directory_name_hash.sv
// ----------------------------------------------------------------------------
// Directory name hash
// Legacy, half-MD4 and TEA directory-index hash of a name, one byte per item.
// ----------------------------------------------------------------------------
//  channel  direction  handshake       payload
//  req_     in         valid / stall   dnh_pkg::req_type
//  rsp_     out        valid / stall   dnh_pkg::rsp_type
//  csr_     in         valid / ready   index, 32-bit data
//
// A legacy byte or a byte that does not close a chunk passes through S_BYTE
// once. A byte that closes a chunk then goes to S_ROUND for the round unit's 24
// (half-MD4) or 32 (TEA) steps, one per cycle, and then the chain takes its result.
// Reset is synchronous, active high.
// A result waits in the output register; the next item is taken only once
// the output register is free.
// ----------------------------------------------------------------------------
module directory_name_hash #(
   parameter int MAX_NAME_LENGTH = 255
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dnh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dnh_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import dnh_pkg::*;

   localparam int LW = $clog2(MAX_NAME_LENGTH + 1);
   localparam logic [LW-1:0] MAXL = LW'(MAX_NAME_LENGTH);

   typedef enum logic [1:0] {S_IDLE, S_BYTE, S_ROUND} state_type;

   state_type   state_ff;
   logic [31:0] seed_ff [4];
   logic [31:0] chain_ff [4];
   logic [31:0] blk_ff [8];
   logic [31:0] recent_ff, older_ff;
   logic [LW-1:0] remain_ff;
   logic [2:0]  mode_ff;
   logic [4:0]  fill_ff;
   logic [7:0]  byte_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rnd_ctl_type ctl;
   logic [31:0] chain_out [4];
   logic        rnd_busy, rnd_done;

   dnh_round u_round (
      .clock(clock), .reset(reset), .ctl(ctl), .blk(blk_ff), .chain_in(chain_ff),
      .chain_out(chain_out), .busy(rnd_busy), .done(rnd_done)
   );

   function automatic logic [1:0] kind_of(input logic [2:0] m);
      unique case (m) inside
         MODE_MD4, MODE_MD4_U: kind_of = KIND_MD4;
         MODE_TEA, MODE_TEA_U: kind_of = KIND_TEA;
         default:              kind_of = KIND_LEGACY;
      endcase
   endfunction

   function automatic rsp_type make_rsp(input logic [31:0] mj, input logic [31:0] mn);
      logic [31:0] m;
      m = {mj[31:1], 1'b0};
      if (m == 32'hfffffffe) m = 32'hfffffffc;
      make_rsp = '{major_word: m, minor_word: mn, hash_error: 1'b0};
   endfunction

   logic [1:0]  kind;
   logic [31:0] bv, mulv, nxt, nxt2;
   logic [LW-1:0] len;
   logic [7:0]  padb;
   logic [LW-1:0] rem_dec;
   logic [4:0]  fill_inc;
   logic [31:0] chain_in [4];
   logic        seed_zero;

   assign kind = kind_of(mode_ff);
   assign bv = (mode_ff < MODE_LEGACY_U && byte_ff[7]) ? {24'hffffff, byte_ff}
                                                       : {24'h0, byte_ff};
   assign mulv = bv * LEG_MULT;
   assign nxt = older_ff + (recent_ff ^ mulv);
   assign nxt2 = nxt[31] ? nxt - LEG_WRAP : nxt;
   assign rem_dec = remain_ff - LW'(1);
   assign fill_inc = fill_ff + 5'd1;
   assign padb = 8'(remain_ff);
   assign seed_zero = ~|(seed_ff[0] | seed_ff[1] | seed_ff[2] | seed_ff[3]);
   assign len = (req_data.name_size > 8'(MAXL) && LW <= 8) ? MAXL
              : LW'(req_data.name_size);

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_ready = 1'b1;

   logic accept;
   logic closes;
   assign accept = req_valid && !req_stall;
   assign closes = (kind == KIND_MD4 && fill_inc == 5'd0) ||
                   (kind == KIND_TEA && fill_inc[3:0] == 4'd0) || rem_dec == '0;
   assign ctl = '{start: (state_ff == S_BYTE) && kind != KIND_LEGACY && closes,
                  kind: kind};

   always_comb begin
      for (int i = 0; i < 4; i++) chain_in[i] = seed_zero ? '0 : seed_ff[i];
      if (seed_zero) begin
         chain_in[0] = MD4_IV0; chain_in[1] = MD4_IV1;
         chain_in[2] = MD4_IV2; chain_in[3] = MD4_IV3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         remain_ff <= '0;
         mode_ff <= '0;
         fill_ff <= '0;
         for (int i = 0; i < 4; i++) seed_ff[i] <= '0;
      end else begin
         if (csr_valid) seed_ff[csr_index - CSR_SEED0] <= csr_data;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  byte_ff <= req_data.name_byte;
                  if (req_data.first_of_name) begin
                     fill_ff <= '0;
                     remain_ff <= '0;
                     if (req_data.hash_mode > MODE_TEA_U) begin
                        rsp_ff <= '{major_word: '0, minor_word: '0, hash_error: 1'b1};
                        rsp_valid_ff <= 1'b1;
                     end else begin
                        mode_ff <= req_data.hash_mode;
                        chain_ff <= chain_in;
                        recent_ff <= LEG_RECENT0;
                        older_ff <= LEG_OLDER0;
                        remain_ff <= len;
                        if (len == '0) begin
                           case (kind_of(req_data.hash_mode))
                              KIND_LEGACY:
                                 rsp_ff <= make_rsp({LEG_RECENT0[30:0], 1'b0}, '0);
                              KIND_MD4: rsp_ff <= make_rsp(chain_in[1], chain_in[2]);
                              default: rsp_ff <= make_rsp(chain_in[0], chain_in[1]);
                           endcase
                           rsp_valid_ff <= 1'b1;
                        end else state_ff <= S_BYTE;
                     end
                  end else if (remain_ff != '0) state_ff <= S_BYTE;
               end
            end
            S_BYTE: begin
               remain_ff <= rem_dec;
               if (kind == KIND_LEGACY) begin
                  older_ff <= recent_ff;
                  recent_ff <= nxt2;
                  state_ff <= S_IDLE;
                  if (rem_dec == '0) begin
                     rsp_ff <= make_rsp({nxt2[30:0], 1'b0}, '0);
                     rsp_valid_ff <= 1'b1;
                  end
               end else begin
                  // The first byte of a chunk pads every word before shifting in.
                  for (int i = 0; i < 8; i++) begin
                     if (3'(i) == fill_ff[4:2])
                        blk_ff[i] <= bv + (((fill_ff == '0) ? {4{padb}} : blk_ff[i]) << 8);
                     else if (fill_ff == '0)
                        blk_ff[i] <= {4{padb}};
                  end
                  fill_ff <= closes ? 5'd0 : fill_inc;
                  state_ff <= closes ? S_ROUND : S_IDLE;
               end
            end
            S_ROUND: begin
               if (rnd_done) begin
                  chain_ff <= chain_out;
                  state_ff <= S_IDLE;
                  if (remain_ff == '0) begin
                     rsp_ff <= (kind == KIND_MD4) ? make_rsp(chain_out[1], chain_out[2])
                                                  : make_rsp(chain_out[0], chain_out[1]);
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_round_only_in_round: assert property (@(posedge clock) disable iff (reset)
      rnd_busy |-> state_ff == S_ROUND) else $error("round unit busy outside round");
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall) else $error("input open with result pending");
   a_done_ends_round: assert property (@(posedge clock) disable iff (reset)
      rnd_done |=> state_ff == S_IDLE) else $error("round end not taken");

endmodule
